// ===== hdl/hdlc_bit_unstuff_deframer_assert.svh =====
// ----------------------------------------------------------------------------
// hdlc_bit_unstuff_deframer_assert.svh
// Assertion macros for the HDLC deframer; empty when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef HDLC_BIT_UNSTUFF_DEFRAMER_ASSERT_SVH
`define HDLC_BIT_UNSTUFF_DEFRAMER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// General clocked property with asynchronous reset disable
`define HDLCD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be true at a clock edge
`define HDLCD_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define HDLCD_ASSERT(lbl, clk, rstn, prop, msg)
`define HDLCD_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

// ===== hdl/hdlcd_pkg.sv =====
// ----------------------------------------------------------------------------
// hdlcd_pkg
// Types and constants shared by the HDLC bit-unstuffing deframer.
// ----------------------------------------------------------------------------
package hdlcd_pkg;

    localparam int MAX_BYTES    = 256;
    localparam int MAX_RAW_BITS = 2592;

    localparam int RAW_W   = $clog2(MAX_RAW_BITS + 1);
    localparam int BYTE_W  = $clog2(MAX_BYTES + 2);
    localparam int DELAY_LEN = 8;

    localparam logic [7:0] FLAG_PATTERN = 8'h7E;
    localparam logic [2:0] ONES_LIMIT   = 3'd5;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SHORT    = 3'd1,
        ST_SIX_ONES = 3'd2,
        ST_PARTIAL  = 3'd3,
        ST_TOO_LONG = 3'd4,
        ST_TOO_MANY = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_RUN,
        SQ_EMIT
    } seq_state_t;

    // Per-frame receiver state
    typedef struct packed {
        logic              in_frame;
        logic [7:0]        flag_window;
        logic [7:0]        delay_bits;
        logic [RAW_W-1:0]  raw_count;
        logic [2:0]        ones_run;
        logic [7:0]        asm_byte;
        logic [2:0]        asm_count;
        logic [BYTE_W-1:0] byte_count;
        logic              ones_error;
    } frm_state_t;

    // What one processed bit produces
    typedef struct packed {
        logic       emit_data;
        logic [7:0] data;
        logic       emit_end;
        status_t    status;
        logic       stop;
    } bu_event_t;

    // Sequencer to result buffer
    typedef struct packed {
        logic       clear;
        logic       put_data;
        logic [7:0] data;
        logic       put_end;
        status_t    status;
        logic       emit;
    } ob_ctrl_t;

    // Result buffer to sequencer
    typedef struct packed {
        logic pend;
        logic data_pend;
        logic end_pend;
    } ob_stat_t;

endpackage

// ===== hdl/hdlcd_if.sv =====
// ----------------------------------------------------------------------------
// hdlcd_in_if / hdlcd_out_if
// Valid/ready channels for received bytes and decoded result items.
// ----------------------------------------------------------------------------
interface hdlcd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hdlcd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    logic       is_end;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output data, output is_end, output status,
                    output last, input ready);
    modport sink   (input valid, input data, input is_end, input status,
                    input last, output ready);
endinterface

// ===== hdl/hdlcd_bit_unit.sv =====
// ----------------------------------------------------------------------------
// hdlcd_bit_unit
// Shared per-bit step: flag hunt, delay line, destuffing and byte packing.
// ----------------------------------------------------------------------------
module hdlcd_bit_unit (
    input  hdlcd_pkg::frm_state_t cur,
    input  logic                  bit_in,
    output hdlcd_pkg::frm_state_t nxt,
    output hdlcd_pkg::bu_event_t  ev
);

    always_comb
    begin
        logic [7:0] win_shift;
        logic       do_pack;
        logic       pbit;

        win_shift = {cur.flag_window[6:0], bit_in};
        do_pack   = 1'b0;
        pbit      = 1'b0;
        nxt       = cur;
        ev        = '0;
        ev.status = hdlcd_pkg::ST_OK;

        if (!cur.in_frame)
        begin
            // Hunt: open a frame on the flag, with everything cleared
            nxt.flag_window = win_shift;
            if (win_shift == hdlcd_pkg::FLAG_PATTERN)
            begin
                nxt          = '0;
                nxt.in_frame = 1'b1;
            end
        end
        else if (cur.raw_count >= hdlcd_pkg::RAW_W'(hdlcd_pkg::MAX_RAW_BITS))
        begin
            // Abort an overlong frame
            ev.emit_end     = 1'b1;
            ev.status       = hdlcd_pkg::ST_TOO_LONG;
            ev.stop         = 1'b1;
            nxt.in_frame    = 1'b0;
            nxt.flag_window = '0;
        end
        else
        begin
            // Destuff the bit leaving the delay line
            if (cur.raw_count >= hdlcd_pkg::RAW_W'(hdlcd_pkg::DELAY_LEN) && !cur.ones_error)
            begin
                if (cur.delay_bits[7])
                begin
                    nxt.ones_run = cur.ones_run + 3'd1;
                    if (cur.ones_run >= hdlcd_pkg::ONES_LIMIT)
                        nxt.ones_error = 1'b1;
                    else
                    begin
                        do_pack = 1'b1;
                        pbit    = 1'b1;
                    end
                end
                else
                begin
                    nxt.ones_run = '0;
                    if (cur.ones_run != hdlcd_pkg::ONES_LIMIT)
                        do_pack = 1'b1;
                end
            end

            // Pack kept bits, MSB first
            if (do_pack)
            begin
                nxt.asm_byte  = {cur.asm_byte[6:0], pbit};
                nxt.asm_count = cur.asm_count + 3'd1;
                if (cur.asm_count == 3'd7)
                begin
                    if (cur.byte_count <= hdlcd_pkg::BYTE_W'(hdlcd_pkg::MAX_BYTES))
                        nxt.byte_count = cur.byte_count + hdlcd_pkg::BYTE_W'(1);
                    if (cur.byte_count < hdlcd_pkg::BYTE_W'(hdlcd_pkg::MAX_BYTES))
                    begin
                        ev.emit_data = 1'b1;
                        ev.data      = {cur.asm_byte[6:0], pbit};
                    end
                end
            end

            // Advance the delay line and flag window
            nxt.raw_count   = cur.raw_count + hdlcd_pkg::RAW_W'(1);
            nxt.delay_bits  = {cur.delay_bits[6:0], bit_in};
            nxt.flag_window = win_shift;

            // Closing flag: report status and go back to hunting
            if (win_shift == hdlcd_pkg::FLAG_PATTERN)
            begin
                ev.emit_end = 1'b1;
                ev.stop     = 1'b1;
                priority if (nxt.raw_count < hdlcd_pkg::RAW_W'(hdlcd_pkg::DELAY_LEN))
                    ev.status = hdlcd_pkg::ST_SHORT;
                else if (nxt.ones_error)
                    ev.status = hdlcd_pkg::ST_SIX_ONES;
                else if (nxt.asm_count != 3'd0)
                    ev.status = hdlcd_pkg::ST_PARTIAL;
                else if (nxt.byte_count > hdlcd_pkg::BYTE_W'(hdlcd_pkg::MAX_BYTES))
                    ev.status = hdlcd_pkg::ST_TOO_MANY;
                else
                    ev.status = hdlcd_pkg::ST_OK;
                nxt.in_frame    = 1'b0;
                nxt.flag_window = '0;
            end
        end
    end

endmodule

// ===== hdl/hdlcd_out_buf.sv =====
// ----------------------------------------------------------------------------
// hdlcd_out_buf
// Holds up to one data item and one end item per input byte and hands
// them out in order, marking the final one.
// ----------------------------------------------------------------------------
module hdlcd_out_buf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  hdlcd_pkg::ob_ctrl_t  ctrl,
    output hdlcd_pkg::ob_stat_t  stat,
    hdlcd_out_if.source          out_ch
);

    logic                data_pend_reg, data_pend_next;
    logic                end_pend_reg,  end_pend_next;
    logic [7:0]          data_reg;
    hdlcd_pkg::status_t  status_reg;
    logic                beat;

    assign beat = out_ch.valid && out_ch.ready;

    // Pending flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_pend_reg <= 1'b0;
            end_pend_reg  <= 1'b0;
        end
        else
        begin
            data_pend_reg <= data_pend_next;
            end_pend_reg  <= end_pend_next;
        end
    end

    always_comb
    begin
        data_pend_next = data_pend_reg;
        end_pend_next  = end_pend_reg;
        priority if (ctrl.clear)
        begin
            data_pend_next = 1'b0;
            end_pend_next  = 1'b0;
        end
        else if (beat)
        begin
            if (data_pend_reg)
                data_pend_next = 1'b0;
            else
                end_pend_next = 1'b0;
        end
        else
        begin
            if (ctrl.put_data)
                data_pend_next = 1'b1;
            if (ctrl.put_end)
                end_pend_next = 1'b1;
        end
    end

    // Payload capture
    always_ff @(posedge clk)
    begin
        if (ctrl.put_data)
            data_reg <= ctrl.data;
        if (ctrl.put_end)
            status_reg <= ctrl.status;
    end

    // Present data first, then the end item
    assign out_ch.valid  = ctrl.emit && (data_pend_reg || end_pend_reg);
    assign out_ch.data   = data_pend_reg ? data_reg : 8'h00;
    assign out_ch.is_end = !data_pend_reg;
    assign out_ch.status = data_pend_reg ? 3'(hdlcd_pkg::ST_OK) : 3'(status_reg);
    assign out_ch.last   = data_pend_reg ? !end_pend_reg : 1'b1;

    assign stat.pend      = data_pend_reg || end_pend_reg;
    assign stat.data_pend = data_pend_reg;
    assign stat.end_pend  = end_pend_reg;

endmodule

// ===== hdl/hdlc_bit_unstuff_deframer.sv =====
// ----------------------------------------------------------------------------
// hdlc_bit_unstuff_deframer
// HDLC flag hunt, bit destuffing and byte assembly, one bit per cycle while a byte is in progress.
// ----------------------------------------------------------------------------
// Operation: a byte is accepted, then runs through the shared bit unit
// one bit per cycle, stopping early at a frame end or abort; its
// results appear in the cycle after its last bit, one beat each (0 to 2 beats).
// Flow: no new byte is accepted until the last one's results have all gone.
// Reset: rst_n clears all frame state; the block starts hunting for a flag.
// ----------------------------------------------------------------------------
`include "hdlc_bit_unstuff_deframer_assert.svh"

module hdlc_bit_unstuff_deframer (
    input  logic        clk,
    input  logic        rst_n,
    hdlcd_in_if.sink    in_ch,
    hdlcd_out_if.source out_ch
);

    hdlcd_pkg::seq_state_t state_reg, state_next;
    hdlcd_pkg::frm_state_t frm_reg, frm_next, bu_nxt;
    hdlcd_pkg::bu_event_t  ev;
    hdlcd_pkg::ob_ctrl_t   ob_ctrl;
    hdlcd_pkg::ob_stat_t   ob_stat;
    logic [7:0]            shift_reg, shift_next;
    logic [2:0]            cnt_reg, cnt_next;
    logic                  in_beat;
    logic                  out_beat;

    assign in_beat  = in_ch.valid && in_ch.ready;
    assign out_beat = out_ch.valid && out_ch.ready;
    assign in_ch.ready = (state_reg == hdlcd_pkg::SQ_IDLE);

    hdlcd_bit_unit u_bit (
        .cur    (frm_reg),
        .bit_in (shift_reg[7]),
        .nxt    (bu_nxt),
        .ev     (ev)
    );

    hdlcd_out_buf u_obuf (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ob_ctrl),
        .stat   (ob_stat),
        .out_ch (out_ch)
    );

    // Sequencer and frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hdlcd_pkg::SQ_IDLE;
            frm_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            frm_reg   <= frm_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

    always_comb
    begin
        state_next = state_reg;
        frm_next   = frm_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        ob_ctrl    = '0;
        ob_ctrl.data   = ev.data;
        ob_ctrl.status = ev.status;

        unique case (state_reg)
            hdlcd_pkg::SQ_IDLE:
            begin
                // Load a new byte and drop old results
                if (in_beat)
                begin
                    shift_next    = in_ch.rx_byte;
                    cnt_next      = '0;
                    ob_ctrl.clear = 1'b1;
                    state_next    = hdlcd_pkg::SQ_RUN;
                end
            end
            hdlcd_pkg::SQ_RUN:
            begin
                // Advance one bit through the shared unit
                frm_next         = bu_nxt;
                shift_next       = {shift_reg[6:0], 1'b0};
                cnt_next         = cnt_reg + 3'd1;
                ob_ctrl.put_data = ev.emit_data;
                ob_ctrl.put_end  = ev.emit_end;
                if (ev.stop || cnt_reg == 3'd7)
                begin
                    if (ob_stat.pend || ev.emit_data || ev.emit_end)
                        state_next = hdlcd_pkg::SQ_EMIT;
                    else
                        state_next = hdlcd_pkg::SQ_IDLE;
                end
            end
            hdlcd_pkg::SQ_EMIT:
            begin
                // Hand out results until the last beat goes
                ob_ctrl.emit = 1'b1;
                if (out_beat && out_ch.last)
                    state_next = hdlcd_pkg::SQ_IDLE;
            end
            default:
            begin
                state_next = hdlcd_pkg::SQ_IDLE;
            end
        endcase
    end

    `HDLCD_NEVER(a_no_out_when_ready, clk, rst_n, in_ch.ready && out_ch.valid, "output valid while taking input")
    `HDLCD_ASSERT(a_accept_runs, clk, rst_n, in_beat |=> (state_reg == hdlcd_pkg::SQ_RUN), "accepted byte did not start processing")
    `HDLCD_ASSERT(a_last_idles, clk, rst_n, (out_beat && out_ch.last) |=> in_ch.ready, "not idle after final result beat")
    `HDLCD_NEVER(a_raw_bound, clk, rst_n, frm_reg.raw_count > hdlcd_pkg::RAW_W'(hdlcd_pkg::MAX_RAW_BITS), "raw bit count past limit")
    `HDLCD_NEVER(a_byte_bound, clk, rst_n, frm_reg.byte_count > hdlcd_pkg::BYTE_W'(hdlcd_pkg::MAX_BYTES + 1), "byte count past saturation")
    `HDLCD_NEVER(a_ones_bound, clk, rst_n, frm_reg.ones_run > 3'd6, "ones run past six")

endmodule
